>>> rtl/cabn_pkg.sv
// Shared constants for the class-aware box suppression block.
package cabn_pkg;
    localparam int SCORE_W   = 8;
    localparam int CLASS_W   = 8;
    localparam int THR_W     = 9;
    localparam int IOU_SHIFT = 8;
    localparam logic [THR_W-1:0] THR_RESET = 9'd128;
endpackage

>>> rtl/class_aware_box_nms.sv
// Top level: greedy class-aware non-maximum suppression over a stored box set.
//
//  channel   | valid      | stall      | payload
//  ----------+------------+------------+------------------------------------------
//  boxes in  | box_valid  | box_stall  | box_left..box_bottom, score, class_index,
//            |            |            | last_box
//  kept out  | res_valid  | res_stall  | out_left..out_bottom, out_score, out_class,
//            |            |            | out_last
//  threshold | iou_threshold_we (no handshake) | iou_threshold_data
//
// Loading accepts one box per cycle while box_stall is low. For a set of N boxes,
// each kept box then costs a best-score scan over all N boxes, a pick and a
// suppression scan over all N boxes, bound by the single read port of the box
// memory; a closing scan that finds nothing left ends the set.
// box_stall is high from the last box of a set until the final kept box is in
// the output register. Reset clears control state and sets the threshold to 128.
// res_stall holds the output register; the engine waits only when it must
// place a new kept box while the previous one is still held.
module class_aware_box_nms
    import cabn_pkg::*;
#(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  iou_threshold_we,
    input  logic [THR_W-1:0]      iou_threshold_data,
    input  logic                  box_valid,
    output logic                  box_stall,
    input  logic [COORD_BITS-1:0] box_left,
    input  logic [COORD_BITS-1:0] box_top,
    input  logic [COORD_BITS-1:0] box_right,
    input  logic [COORD_BITS-1:0] box_bottom,
    input  logic [SCORE_W-1:0]    score,
    input  logic [CLASS_W-1:0]    class_index,
    input  logic                  last_box,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [COORD_BITS-1:0] out_left,
    output logic [COORD_BITS-1:0] out_top,
    output logic [COORD_BITS-1:0] out_right,
    output logic [COORD_BITS-1:0] out_bottom,
    output logic [SCORE_W-1:0]    out_score,
    output logic [CLASS_W-1:0]    out_class,
    output logic                  out_last
);
    localparam int CB = COORD_BITS;
    localparam int IW = $clog2(MAX_BOXES);
    localparam int NW = IW + 1;
    localparam int WW = 4 * CB + SCORE_W + CLASS_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_BOXES);

    // word layout: left, top, right, bottom, score, class (class at bit 0)
    localparam int CL_LO = 0;
    localparam int SC_LO = CLASS_W;
    localparam int B_LO  = SC_LO + SCORE_W;
    localparam int R_LO  = B_LO + CB;
    localparam int T_LO  = R_LO + CB;
    localparam int L_LO  = T_LO + CB;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_PICK  = 3'd2;
    localparam logic [2:0] ST_SUPP  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] DRAIN_CYC = 3'd6;

    logic [2:0]           state_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [NW-1:0]        count_reg;
    logic [NW-1:0]        ptr_reg;
    logic [2:0]           drain_reg;
    logic                 rd_vld_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 best_found_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [WW-1:0]        best_word_reg;
    logic                 have_pend_reg;
    logic [WW-1:0]        pend_word_reg;
    logic                 out_vld_reg;
    logic                 out_last_reg;
    logic [WW-1:0]        out_word_reg;

    logic          box_xfer;
    logic          issue;
    logic          out_free;
    logic          pick_go;
    logic          fin_go;
    logic [WW-1:0] in_word;
    logic [WW-1:0] rd_word;
    logic          done_rd;
    logic          done_we;
    logic [IW-1:0] done_waddr;
    logic          done_wdata;
    logic          cand_open;
    logic          iou_in_vld;
    logic          hit_vld;
    logic [IW-1:0] hit_idx;

    assign box_stall = (state_reg != ST_LOAD);
    assign box_xfer  = box_valid && !box_stall;
    assign out_free  = !out_vld_reg || !res_stall;
    assign issue     = ((state_reg == ST_SCAN) || (state_reg == ST_SUPP))
                       && (ptr_reg < count_reg);
    assign pick_go   = (state_reg == ST_PICK) && best_found_reg
                       && (!have_pend_reg || out_free);
    assign fin_go    = (state_reg == ST_PICK) && !best_found_reg && out_free;
    assign in_word   = {box_left, box_top, box_right, box_bottom, score, class_index};

    cabn_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk     (clk),
        .wr_en   (box_xfer && (count_reg < MAX_N)),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (in_word),
        .rd_en   (issue),
        .rd_addr (ptr_reg[IW-1:0]),
        .rd_data (rd_word)
    );

    // done flags: loading a box clears its flag, a pick or a hit sets it;
    // read alongside the box word so both arrive in the same cycle
    always_comb
    begin
        done_we    = 1'b0;
        done_waddr = count_reg[IW-1:0];
        done_wdata = 1'b0;
        if (state_reg == ST_LOAD)
        begin
            done_we = box_xfer && (count_reg < MAX_N);
        end
        else if (pick_go)
        begin
            done_we    = 1'b1;
            done_waddr = best_idx_reg;
            done_wdata = 1'b1;
        end
        else if (hit_vld)
        begin
            done_we    = 1'b1;
            done_waddr = hit_idx;
            done_wdata = 1'b1;
        end
    end

    cabn_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BOXES)
    ) u_done (
        .clk     (clk),
        .wr_en   (done_we),
        .wr_addr (done_waddr),
        .wr_data (done_wdata),
        .rd_en   (issue),
        .rd_addr (ptr_reg[IW-1:0]),
        .rd_data (done_rd)
    );

    assign cand_open  = rd_vld_reg && !done_rd;
    assign iou_in_vld = (state_reg == ST_SUPP || state_reg == ST_DRAIN) && cand_open
                        && (rd_word[CL_LO +: CLASS_W] == pend_word_reg[CL_LO +: CLASS_W]);

    cabn_iou #(
        .CB (CB),
        .IW (IW)
    ) u_iou (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (iou_in_vld),
        .in_idx  (rd_idx_reg),
        .c_l     (rd_word[L_LO +: CB]),
        .c_t     (rd_word[T_LO +: CB]),
        .c_r     (rd_word[R_LO +: CB]),
        .c_b     (rd_word[B_LO +: CB]),
        .k_l     (pend_word_reg[L_LO +: CB]),
        .k_t     (pend_word_reg[T_LO +: CB]),
        .k_r     (pend_word_reg[R_LO +: CB]),
        .k_b     (pend_word_reg[B_LO +: CB]),
        .thr     (thr_reg),
        .hit_vld (hit_vld),
        .hit_idx (hit_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            thr_reg        <= THR_RESET;
            count_reg      <= '0;
            ptr_reg        <= '0;
            drain_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            have_pend_reg  <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (iou_threshold_we)
            begin
                thr_reg <= iou_threshold_data;
            end
            if ((pick_go && have_pend_reg) || fin_go)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_vld_reg && !res_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            rd_vld_reg <= issue;
            rd_idx_reg <= ptr_reg[IW-1:0];
            if (issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (box_xfer)
                    begin
                        if (count_reg < MAX_N)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (last_box)
                        begin
                            ptr_reg        <= '0;
                            best_found_reg <= 1'b0;
                            have_pend_reg  <= 1'b0;
                            state_reg      <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // strict compare keeps the earlier box on equal scores
                    if (cand_open && (!best_found_reg ||
                        rd_word[SC_LO +: SCORE_W] > best_word_reg[SC_LO +: SCORE_W]))
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= rd_idx_reg;
                    end
                    if (!issue && !rd_vld_reg)
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    if (pick_go)
                    begin
                        if (have_pend_reg)
                        begin
                            out_last_reg <= 1'b0;
                        end
                        have_pend_reg <= 1'b1;
                        ptr_reg       <= '0;
                        state_reg     <= ST_SUPP;
                    end
                    else if (fin_go)
                    begin
                        out_last_reg <= 1'b1;
                        count_reg    <= '0;
                        state_reg    <= ST_LOAD;
                    end
                end
                ST_SUPP:
                begin
                    if (!issue)
                    begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == DRAIN_CYC)
                    begin
                        ptr_reg        <= '0;
                        best_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && cand_open && (!best_found_reg ||
            rd_word[SC_LO +: SCORE_W] > best_word_reg[SC_LO +: SCORE_W]))
        begin
            best_word_reg <= rd_word;
        end
        if (state_reg == ST_PICK && out_free)
        begin
            out_word_reg <= pend_word_reg;
        end
        if (pick_go)
        begin
            pend_word_reg <= best_word_reg;
        end
    end

    assign res_valid  = out_vld_reg;
    assign out_left   = out_word_reg[L_LO +: CB];
    assign out_top    = out_word_reg[T_LO +: CB];
    assign out_right  = out_word_reg[R_LO +: CB];
    assign out_bottom = out_word_reg[B_LO +: CB];
    assign out_score  = out_word_reg[SC_LO +: SCORE_W];
    assign out_class  = out_word_reg[CL_LO +: CLASS_W];
    assign out_last   = out_last_reg;
endmodule

>>> rtl/cabn_ram.sv
// Generic simple dual-port RAM with registered read.
module cabn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> rtl/cabn_iou.sv
// Pipelined IoU threshold test of one candidate against the kept box.
module cabn_iou
    import cabn_pkg::*;
#(
    parameter int CB = 12,
    parameter int IW = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  logic [IW-1:0]    in_idx,
    input  logic [CB-1:0]    c_l,
    input  logic [CB-1:0]    c_t,
    input  logic [CB-1:0]    c_r,
    input  logic [CB-1:0]    c_b,
    input  logic [CB-1:0]    k_l,
    input  logic [CB-1:0]    k_t,
    input  logic [CB-1:0]    k_r,
    input  logic [CB-1:0]    k_b,
    input  logic [THR_W-1:0] thr,
    output logic             hit_vld,
    output logic [IW-1:0]    hit_idx
);
    localparam int AW = 2 * CB;
    localparam int UW = AW + 1;
    localparam int PW = UW + THR_W;

    logic [CB-1:0] x1, y1, x2, y2;
    logic [CB-1:0] ox_reg, oy_reg, cw_reg, ch_reg, kw_reg, kh_reg;
    logic [AW-1:0] inter_reg, ca_reg, ka_reg;
    logic [AW-1:0] inter3_reg;
    logic [UW-1:0] uni_reg;
    logic [3:0]    vld_reg;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic          hit_reg;
    logic [PW-1:0] lhs, rhs;

    assign x1 = (c_l > k_l) ? c_l : k_l;
    assign y1 = (c_t > k_t) ? c_t : k_t;
    assign x2 = (c_r < k_r) ? c_r : k_r;
    assign y2 = (c_b < k_b) ? c_b : k_b;

    // intersection * 256 >= threshold * union
    assign lhs = PW'(inter3_reg) << IOU_SHIFT;
    assign rhs = PW'(thr) * PW'(uni_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg   <= (x1 < x2) ? CB'(x2 - x1) : '0;
        oy_reg   <= (y1 < y2) ? CB'(y2 - y1) : '0;
        cw_reg   <= (c_l < c_r) ? CB'(c_r - c_l) : '0;
        ch_reg   <= (c_t < c_b) ? CB'(c_b - c_t) : '0;
        kw_reg   <= (k_l < k_r) ? CB'(k_r - k_l) : '0;
        kh_reg   <= (k_t < k_b) ? CB'(k_b - k_t) : '0;
        idx1_reg <= in_idx;

        inter_reg <= AW'(ox_reg) * AW'(oy_reg);
        ca_reg    <= AW'(cw_reg) * AW'(ch_reg);
        ka_reg    <= AW'(kw_reg) * AW'(kh_reg);
        idx2_reg  <= idx1_reg;

        uni_reg    <= UW'(ca_reg) + UW'(ka_reg) - UW'(inter_reg);
        inter3_reg <= inter_reg;
        idx3_reg   <= idx2_reg;

        hit_reg  <= (uni_reg != '0) && (lhs >= rhs);
        idx4_reg <= idx3_reg;
    end

    assign hit_vld = vld_reg[3] & hit_reg;
    assign hit_idx = idx4_reg;
endmodule

>>> rtl/cabn_checker.sv
// Port-level checks for the suppression block, bound to the top level.
module cabn_checker
    import cabn_pkg::*;
#(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  box_valid,
    input logic                  box_stall,
    input logic                  last_box,
    input logic                  res_valid,
    input logic                  res_stall,
    input logic [COORD_BITS-1:0] out_left,
    input logic [SCORE_W-1:0]    out_score,
    input logic                  out_last
);
    // a set closes on its last box: the input side blocks at once
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_stall && last_box |=> box_stall)
        else $error("input not blocked after last box");

    // a box that does not close the set leaves the input open
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_stall && !last_box |=> !box_stall)
        else $error("input blocked while loading");

    // held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(out_left)
        && $stable(out_score) && $stable(out_last))
        else $error("stalled result changed");
endmodule

bind class_aware_box_nms cabn_checker #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
) u_cabn_checker (.*);
